>>> src/glodu_pkg.sv
// Package for the log-odds grid ray updater: sizes, register indexes,
// the job record passed from front to back, and small helpers.
// No dependencies.
`timescale 1ns / 1ps

package glodu_pkg;

   // default grid size
   localparam int GRID_WIDTH_DEF  = 256;
   localparam int GRID_HEIGHT_DEF = 256;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int COORD_W = 11;
   localparam int DELTA_W = 12;
   localparam int STEPS_W = 11;
   localparam int CELL_W  = 16;

   // control register indexes
   localparam logic [1:0] CSR_OCCUPIED_STEP = 2'd0;
   localparam logic [1:0] CSR_FREE_STEP     = 2'd1;
   localparam logic [1:0] CSR_MAX_RANGE     = 2'd2;

   // reset values of the control registers
   localparam logic [15:0] OCCUPIED_STEP_RST = 16'd217;
   localparam logic [15:0] FREE_STEP_RST     = 16'hFF27;
   localparam logic [15:0] MAX_RANGE_RST     = 16'd1280;

   // cleared cell value, -1.0 in Q8.8
   localparam logic signed [CELL_W-1:0] CELL_RST = -16'sd256;

   // function codes
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // classified item handed to the back end
   typedef struct packed {
      logic                       is_read;
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  end_x;
      logic signed [COORD_W-1:0]  end_y;
      logic signed [DELTA_W-1:0]  delta_x;
      logic signed [DELTA_W-1:0]  delta_y;
      logic        [STEPS_W-1:0]  steps;
      logic                       do_corners;
      logic                       end_occupied;
   } job_type;

   // saturating Q8.8 add
   function automatic logic signed [CELL_W-1:0] sat_add(
      input logic signed [CELL_W-1:0] a,
      input logic signed [CELL_W-1:0] b
   );
      logic signed [CELL_W:0] s;
      s = {a[CELL_W-1], a} + {b[CELL_W-1], b};
      if (s[CELL_W] != s[CELL_W-1]) begin
         sat_add = s[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
      end else begin
         sat_add = s[CELL_W-1:0];
      end
   endfunction

endpackage

>>> src/grid_ray_log_odds_update_top.sv
// Top level of the log-odds grid ray updater: control registers, front end,
// job queue and back end. Uses glodu_pkg, glodu_front, glodu_queue, glodu_back.
//
// After reset the block clears every grid cell to -1.0, one cell per cycle;
// meanwhile up to three items are taken into the front register and the queue
// but none is carried out, and control writes are taken. Every cell update is
// a read-modify-write of a single-port-write RAM with registered read, so a
// ray cell inside the grid passes the address, read and write-back states and
// a cell outside it the address state only; an update item visits steps+1 ray
// cells, steps = max(|dx|,|dy|), then the four end corners unless the beam
// range equals the maximum range, and a read item only its end cell. The
// front end and a two-entry queue take further items while the back end
// works, and a result register holds a finished result until it is taken.
`timescale 1ns / 1ps

module grid_ray_log_odds_update_top import glodu_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic                      req_end_occupied,
   input  logic [15:0]               req_beam_range,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [CELL_W-1:0]  rsp_cell_value,
   output logic                      rsp_cell_inside,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata
);

   logic [15:0] occ_step_ff, free_step_ff, max_range_ff;
   logic    fr_valid, fr_ready, q_valid, q_pop;
   job_type fr_job, q_job;

   // control registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_step_ff  <= OCCUPIED_STEP_RST;
         free_step_ff <= FREE_STEP_RST;
         max_range_ff <= MAX_RANGE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OCCUPIED_STEP: occ_step_ff  <= csr_wdata;
            CSR_FREE_STEP:     free_step_ff <= csr_wdata;
            CSR_MAX_RANGE:     max_range_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   glodu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_end_occupied (req_end_occupied),
      .req_beam_range   (req_beam_range),
      .max_range        (max_range_ff),
      .job_valid        (fr_valid),
      .job_ready        (fr_ready),
      .job              (fr_job)
   );

   glodu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_job   (fr_job),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_job    (q_job)
   );

   glodu_back #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (q_valid),
      .job_pop         (q_pop),
      .job             (q_job),
      .occupied_step   ($signed(occ_step_ff)),
      .free_step       ($signed(free_step_ff)),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_cell_inside (rsp_cell_inside)
   );

endmodule

>>> src/glodu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module glodu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/glodu_front.sv
// Front end: accepts request items, computes ray deltas and step count,
// and holds the classified job until the queue takes it. Uses glodu_pkg.
`timescale 1ns / 1ps

module glodu_front import glodu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic                      req_end_occupied,
   input  logic [15:0]               req_beam_range,
   input  logic [15:0]               max_range,
   output logic                      job_valid,
   input  logic                      job_ready,
   output job_type                   job
);

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic signed [DELTA_W-1:0] dx, dy;
   logic [DELTA_W-1:0] adx, ady;

   // deltas and step count
   always_comb begin
      dx  = {req_end_x[COORD_W-1], req_end_x} - {req_start_x[COORD_W-1], req_start_x};
      dy  = {req_end_y[COORD_W-1], req_end_y} - {req_start_y[COORD_W-1], req_start_y};
      adx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
      ady = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
      job_in.is_read      = (req_func == FUNC_READ);
      job_in.start_x      = req_start_x;
      job_in.start_y      = req_start_y;
      job_in.end_x        = req_end_x;
      job_in.end_y        = req_end_y;
      job_in.delta_x      = dx;
      job_in.delta_y      = dy;
      job_in.steps        = (adx > ady) ? adx[STEPS_W-1:0] : ady[STEPS_W-1:0];
      job_in.do_corners   = (req_beam_range != max_range);
      job_in.end_occupied = req_end_occupied;
   end

   assign req_ready = !valid_ff || job_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (job_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

>>> src/glodu_queue.sv
// Short job queue between front and back end.
// Uses glodu_pkg for the job record.
`timescale 1ns / 1ps

module glodu_queue import glodu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop,
   output job_type pop_job
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(do_push) - CW'(do_pop);
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> src/glodu_back.sv
// Back end: clears the grid after reset, then walks each update job cell
// by cell with a read-modify-write of the grid RAM, reads the end cell of
// each read job, and emits one result per job. Uses glodu_pkg and glodu_ram.
`timescale 1ns / 1ps

module glodu_back import glodu_pkg::*; #(
   parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   output logic                     job_pop,
   input  job_type                  job,
   input  logic signed [CELL_W-1:0] occupied_step,
   input  logic signed [CELL_W-1:0] free_step,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [CELL_W-1:0] rsp_cell_value,
   output logic                     rsp_cell_inside
);

   localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(GRID_WIDTH);
   localparam int YW    = $clog2(GRID_HEIGHT);

   // signed one at delta width
   localparam logic signed [DELTA_W-1:0] ONE_D = DELTA_W'(1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_ADDR  = 6'b000100,
      S_READ  = 6'b001000,
      S_WRITE = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic [STEPS_W-1:0] i_ff, i_in, rx_ff, rx_in, ry_ff, ry_in;
   logic signed [DELTA_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic corner_ff, corner_in;
   logic [1:0] k_ff, k_in;
   logic [AW-1:0] addr_ff, addr_in, clr_ff;
   logic signed [CELL_W-1:0] res_value_ff, res_value_in;
   logic res_inside_ff, res_inside_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [CELL_W-1:0] rsp_value_ff;
   logic rsp_inside_ff;

   logic signed [DELTA_W-1:0] cx, cy, wx, wy;
   logic cell_in_grid, adv_done;
   logic signed [DELTA_W:0] tx, ty;
   logic signed [CELL_W-1:0] step_val, rd_data, sum;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata, mem_rdata;

   // current walk cell: floor quotient turned into truncation toward zero
   assign wx = (rx_ff != '0 && qx_ff < 0) ? qx_ff + ONE_D : qx_ff;
   assign wy = (ry_ff != '0 && qy_ff < 0) ? qy_ff + ONE_D : qy_ff;

   // select the cell of this visit
   always_comb begin
      if (job_ff.is_read) begin
         cx = {job_ff.end_x[COORD_W-1], job_ff.end_x};
         cy = {job_ff.end_y[COORD_W-1], job_ff.end_y};
      end else if (corner_ff) begin
         cx = {job_ff.end_x[COORD_W-1], job_ff.end_x} - ONE_D + DELTA_W'(k_ff[1]);
         cy = {job_ff.end_y[COORD_W-1], job_ff.end_y} - ONE_D + DELTA_W'(k_ff[0]);
      end else begin
         cx = wx;
         cy = wy;
      end
      cell_in_grid = (cx >= 0) && (cx < $signed(DELTA_W'(GRID_WIDTH)))
                  && (cy >= 0) && (cy < $signed(DELTA_W'(GRID_HEIGHT)));
   end

   // step for this visit
   assign step_val = (corner_ff && job_ff.end_occupied) ? occupied_step : free_step;

   // next-position candidates for the walk
   assign tx = $signed({2'b00, rx_ff}) + {job_ff.delta_x[DELTA_W-1], job_ff.delta_x};
   assign ty = $signed({2'b00, ry_ff}) + {job_ff.delta_y[DELTA_W-1], job_ff.delta_y};

   assign rd_data = $signed(mem_rdata);
   assign sum     = sat_add(rd_data, step_val);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      i_in          = i_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      corner_in     = corner_ff;
      k_in          = k_ff;
      addr_in       = addr_ff;
      res_value_in  = res_value_ff;
      res_inside_in = res_inside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      job_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = sum;
      adv_done      = 1'b0;

      // whether this visit is the last of the job
      if (corner_ff) begin
         adv_done = (k_ff == 2'd3);
      end else if (i_ff == job_ff.steps) begin
         adv_done = !job_ff.do_corners;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = CELL_RST;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop       = 1'b1;
               job_in        = job;
               i_in          = '0;
               rx_in         = '0;
               ry_in         = '0;
               qx_in         = {job.start_x[COORD_W-1], job.start_x};
               qy_in         = {job.start_y[COORD_W-1], job.start_y};
               corner_in     = 1'b0;
               k_in          = '0;
               res_value_in  = '0;
               res_inside_in = 1'b0;
               state_in      = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in = AW'(cy[YW-1:0]) * AW'(GRID_WIDTH) + AW'(cx[XW-1:0]);
            if (cell_in_grid) begin
               state_in = S_READ;
            end else if (job_ff.is_read || adv_done) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (job_ff.is_read) begin
               res_value_in  = rd_data;
               res_inside_in = 1'b1;
               state_in      = S_RESP;
            end else begin
               mem_we   = 1'b1;
               state_in = adv_done ? S_RESP : S_ADDR;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step the walk or corner counter when a visit ends
      if (!job_ff.is_read && !adv_done
          && ((state_ff == S_ADDR && !cell_in_grid) || state_ff == S_WRITE)) begin
         if (corner_ff) begin
            k_in = k_ff + 2'd1;
         end else if (i_ff == job_ff.steps) begin
            corner_in = 1'b1;
            k_in      = '0;
         end else begin
            i_in = i_ff + 1'b1;
            if (tx >= $signed({2'b00, job_ff.steps})) begin
               rx_in = STEPS_W'(tx - $signed({2'b00, job_ff.steps}));
               qx_in = qx_ff + ONE_D;
            end else if (tx < 0) begin
               rx_in = STEPS_W'(tx + $signed({2'b00, job_ff.steps}));
               qx_in = qx_ff - ONE_D;
            end else begin
               rx_in = STEPS_W'(tx);
            end
            if (ty >= $signed({2'b00, job_ff.steps})) begin
               ry_in = STEPS_W'(ty - $signed({2'b00, job_ff.steps}));
               qy_in = qy_ff + ONE_D;
            end else if (ty < 0) begin
               ry_in = STEPS_W'(ty + $signed({2'b00, job_ff.steps}));
               qy_in = qy_ff - ONE_D;
            end else begin
               ry_in = STEPS_W'(ty);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      job_ff        <= job_in;
      i_ff          <= i_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      corner_ff     <= corner_in;
      k_ff          <= k_in;
      addr_ff       <= addr_in;
      res_value_ff  <= res_value_in;
      res_inside_ff <= res_inside_in;
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
         rsp_value_ff  <= res_value_ff;
         rsp_inside_ff <= res_inside_ff;
      end
   end

   glodu_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_value_ff;
   assign rsp_cell_inside = rsp_inside_ff;

   // grid is written only by the clearing pass or a write-back
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_WRITE))
      else $error("grid write outside clear or write-back");

   // jobs are taken only when idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == S_IDLE)
      else $error("job taken while busy");

   // a read is always followed by its write-back cycle
   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_WRITE)
      else $error("read not followed by write-back");

   // walk remainders stay below the step count
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR && !corner_ff && !job_ff.is_read && job_ff.steps != '0)
      |-> (rx_ff < job_ff.steps && ry_ff < job_ff.steps))
      else $error("walk remainder out of range");

   // a result outside the grid carries a zero value
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_inside_ff) |-> rsp_value_ff == '0)
      else $error("nonzero value on result outside grid");

endmodule

>>> sim/tb.sv
// Testbench for grid_ray_log_odds_update_top: drives ray updates and cell reads,
// predicts every result with a shadow log-odds grid and checks it.
// Depends on glodu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import glodu_pkg::*;

   localparam int GW = GRID_WIDTH_DEF;
   localparam int GH = GRID_HEIGHT_DEF;
   localparam int GAP_MAX = 5;

   typedef struct {
      logic                      func;
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
      logic                      occ;
      logic [15:0]               beam;
   } ray_item_type;

   typedef struct {
      logic signed [CELL_W-1:0] value;
      logic                     cell_in;
   } cell_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_func = 1'b0;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_start_y = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_end_y = '0;
   logic                      req_end_occupied = 1'b0;
   logic [15:0]               req_beam_range = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [CELL_W-1:0]  rsp_cell_value;
   logic                      rsp_cell_inside;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index = '0;
   logic [15:0]               csr_wdata = '0;

   // shadow copy of the grid and the registers
   logic signed [CELL_W-1:0] shadow_odds [0:GW*GH-1];
   logic signed [15:0]       occ_step_q, free_step_q;
   logic [15:0]              max_range_q;

   cell_result_type pending_cells[$];
   int  errors = 0;
   int  items_sent = 0, reads_sent = 0, results_seen = 0;
   bit  no_idle = 1'b0;
   int  rsp_hold = 0;

   grid_ray_log_odds_update_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #400ms;
      $display("tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // shadow grid update
   function automatic void bump_cell(int x, int y, int stp);
      int s;
      if (x < 0 || x >= GW || y < 0 || y >= GH) return;
      s = int'(shadow_odds[y*GW + x]) + stp;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      shadow_odds[y*GW + x] = s[15:0];
   endfunction

   // result of one item, applying its effect on the shadow grid
   function automatic cell_result_type predict_cell(ray_item_type it);
      cell_result_type r;
      int sx, sy, ex, ey, dx, dy, steps, cstep;
      sx = it.sx; sy = it.sy; ex = it.ex; ey = it.ey;
      r.value = '0;
      r.cell_in = 1'b0;
      if (it.func == FUNC_READ) begin
         if (ex >= 0 && ex < GW && ey >= 0 && ey < GH) begin
            r.value = shadow_odds[ey*GW + ex];
            r.cell_in = 1'b1;
         end
         return r;
      end
      dx = ex - sx;
      dy = ey - sy;
      steps = (dx < 0) ? -dx : dx;
      if (((dy < 0) ? -dy : dy) > steps) steps = (dy < 0) ? -dy : dy;
      if (steps == 0) bump_cell(sx, sy, free_step_q);
      else
         for (int i = 0; i <= steps; i++)
            bump_cell((sx*steps + i*dx) / steps, (sy*steps + i*dy) / steps, free_step_q);
      // end corner, unless the beam reported no return
      if (it.beam != max_range_q) begin
         cstep = it.occ ? int'(occ_step_q) : int'(free_step_q);
         bump_cell(ex-1, ey-1, cstep);
         bump_cell(ex-1, ey, cstep);
         bump_cell(ex, ey-1, cstep);
         bump_cell(ex, ey, cstep);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // send one item; valid is only lowered when a gap follows
   task automatic send_item(ray_item_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= it.func;
      req_start_x      <= it.sx;
      req_start_y      <= it.sy;
      req_end_x        <= it.ex;
      req_end_y        <= it.ey;
      req_end_occupied <= it.occ;
      req_beam_range   <= it.beam;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_cells = {pending_cells, predict_cell(it)};
      items_sent++;
      if (it.func == FUNC_READ) reads_sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every result, then for the block to settle
   task automatic drain();
      stop_sending();
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // write all three registers, one item per register
   task automatic write_regs(logic [15:0] occ, logic [15:0] free, logic [15:0] maxr);
      logic [15:0] vals [3];
      vals = '{occ, free, maxr};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? CSR_OCCUPIED_STEP : (k == 1) ? CSR_FREE_STEP : CSR_MAX_RANGE;
         csr_wdata <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      occ_step_q  = occ;
      free_step_q = free;
      max_range_q = maxr;
   endtask

   function automatic ray_item_type make_item(bit f, int sx, int sy, int ex, int ey,
                                              bit occ, int beam);
      ray_item_type it;
      it.func = f;
      it.sx = COORD_W'(sx); it.sy = COORD_W'(sy);
      it.ex = COORD_W'(ex); it.ey = COORD_W'(ey);
      it.occ = occ;
      it.beam = 16'(beam);
      return it;
   endfunction

   // mostly short rays, some in a small patch so cells get hit again and read back
   function automatic ray_item_type rand_item();
      ray_item_type it;
      int kind, cx, cy;
      kind = $urandom_range(0, 99);
      cx = $urandom_range(0, GW-1);
      cy = $urandom_range(0, GH-1);
      if (kind < 30) begin
         cx = $urandom_range(0, 15);
         cy = $urandom_range(0, 15);
      end
      it.func = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_UPDATE;
      it.sx = COORD_W'(cx);
      it.sy = COORD_W'(cy);
      it.ex = COORD_W'(cx + $urandom_range(0, 48) - 24);
      it.ey = COORD_W'(cy + $urandom_range(0, 48) - 24);
      it.occ = 1'($urandom_range(0, 1));
      it.beam = ($urandom_range(0, 9) == 0) ? max_range_q : 16'($urandom);
      if (kind >= 95) begin
         // full range coordinates, mostly far outside the grid
         it.sx = COORD_W'($urandom); it.sy = COORD_W'($urandom);
         it.ex = COORD_W'($urandom); it.ey = COORD_W'($urandom);
      end else if (kind >= 90) begin
         // rays starting near the left or right grid edge
         it.sx = COORD_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : GW - 1 - $urandom_range(0, 3));
         it.ex = COORD_W'(it.sx + $urandom_range(0, 8) - 4);
      end
      return it;
   endfunction

   // ------------------------------------------------------------------
   // result side: random stalls, long hold when asked
   initial begin
      cell_result_type exp_r;
      int stall;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end else stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_seen++;
         if (pending_cells.size() == 0) begin
            $display("%0t: result with none expected: value %0d inside %0b",
                     $time, rsp_cell_value, rsp_cell_inside);
            errors++;
         end else begin
            exp_r = pending_cells.pop_front();
            if (rsp_cell_value !== exp_r.value) begin
               $display("%0t: cell_value expected %0d actual %0d",
                        $time, exp_r.value, rsp_cell_value);
               errors++;
            end
            if (rsp_cell_inside !== exp_r.cell_in) begin
               $display("%0t: cell_inside expected %0b actual %0b",
                        $time, exp_r.cell_in, rsp_cell_inside);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   task automatic test_reads_after_reset();
      send_item(make_item(FUNC_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, GW-1, GH-1, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, -1, 0, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 0, -1, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, GW, 0, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 0, GH, 0, 0));
      send_item(make_item(FUNC_READ, -1024, -1024, 1023, 1023, 1, 16'hFFFF));
      send_item(make_item(FUNC_READ, 1023, 1023, -1024, -1024, 1, 0));
      drain();
   endtask

   task automatic test_directed_rays();
      // zero-length ray, with and without the end corner
      send_item(make_item(FUNC_UPDATE, 5, 5, 5, 5, 1, 100));
      send_item(make_item(FUNC_UPDATE, 9, 9, 9, 9, 0, max_range_q));
      // corner at the origin, partly outside
      send_item(make_item(FUNC_UPDATE, 3, 0, 0, 0, 1, 0));
      // steep and shallow rays in three octants
      send_item(make_item(FUNC_UPDATE, 20, 20, 27, 40, 0, 1));
      send_item(make_item(FUNC_UPDATE, 20, 20, 2, 13, 1, 2));
      send_item(make_item(FUNC_UPDATE, 20, 20, 31, 2, 1, 3));
      // grid-spanning diagonal, far outside on both ends
      send_item(make_item(FUNC_UPDATE, -1024, -1024, 1023, 1023, 1, 16'hFFFF));
      send_item(make_item(FUNC_UPDATE, 1023, -1024, -1024, 1023, 0, 0));
      // ray entirely outside
      send_item(make_item(FUNC_UPDATE, -50, -40, -10, -5, 1, 7));
      // far edge corner
      send_item(make_item(FUNC_UPDATE, GW-1, GH-1, GW-1, GH-1, 1, 9));
      send_item(make_item(FUNC_READ, 0, 0, 5, 5, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 4, 4, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 0, 0, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 27, 40, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, 100, 100, 0, 0));
      send_item(make_item(FUNC_READ, 0, 0, GW-1, GH-1, 0, 0));
      drain();
   endtask

   // large steps drive the same cells into both rails
   task automatic test_saturation(logic [15:0] occ, logic [15:0] free, logic [15:0] maxr);
      write_regs(occ, free, maxr);
      for (int k = 0; k < 6; k++) begin
         send_item(make_item(FUNC_UPDATE, 40, 40, 44, 42, k[0], 16'(maxr + 1)));
         send_item(make_item(FUNC_READ, 0, 0, 44, 42, 0, 0));
         send_item(make_item(FUNC_READ, 0, 0, 40, 40, 0, 0));
      end
      drain();
   endtask

   // receiver holds off while the sender keeps going
   task automatic test_backpressure();
      no_idle = 1'b1;
      rsp_hold = 600;
      for (int k = 0; k < 30; k++) send_item(rand_item());
      no_idle = 1'b0;
      drain();
   endtask

   task automatic test_random(int n, bit burst);
      no_idle = burst;
      for (int k = 0; k < n; k++) send_item(rand_item());
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      for (int k = 0; k < GW*GH; k++) shadow_odds[k] = CELL_RST;
      occ_step_q  = OCCUPIED_STEP_RST;
      free_step_q = FREE_STEP_RST;
      max_range_q = MAX_RANGE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reads_after_reset();
      test_directed_rays();
      test_saturation(16'h7FFF, 16'h8000, 16'd0);
      test_saturation(16'h8000, 16'h7FFF, 16'hFFFF);
      write_regs(OCCUPIED_STEP_RST, FREE_STEP_RST, MAX_RANGE_RST);
      test_random(300, 1'b0);
      test_backpressure();
      write_regs(16'($urandom_range(1, 900)), 16'(-$urandom_range(1, 900)),
                 16'($urandom));
      test_random(300, 1'b0);
      write_regs(16'($urandom), 16'($urandom), 16'($urandom));
      test_random(100, 1'b1);
      write_regs(OCCUPIED_STEP_RST, FREE_STEP_RST, MAX_RANGE_RST);
      test_random(250, 1'b0);

      $display("Covered %0d items (%0d cell reads), %0d results checked,", items_sent,
               reads_sent, results_seen);
      $display("register extremes, saturation, edge rays and a long result stall.");
      if (errors == 0 && pending_cells.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/glodu_pkg.sv
src/glodu_ram.sv
src/glodu_front.sv
src/glodu_queue.sv
src/glodu_back.sv
src/grid_ray_log_odds_update_top.sv
sim/tb.sv
